@@ hw/rtl/sdfspc_pkg.sv @@
package sdfspc_pkg;

    localparam int DEF_COORD_BITS = 11;
    localparam int DEF_FRAC_BITS  = 16;

    // Register file layout.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 11;
    localparam int HALF_BITS      = 10;
    localparam int PSHIFT_BITS    = 11;
    localparam int CSHIFT_BITS    = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_HALF_WIDTH       = 3'd0,
        REG_HALF_HEIGHT      = 3'd1,
        REG_PENTAGON_SHIFT_X = 3'd2,
        REG_PENTAGON_SHIFT_Y = 3'd3,
        REG_CIRCLE_SHIFT_X   = 3'd4,
        REG_CIRCLE_SHIFT_Y   = 3'd5
    } sdfspc_reg_t;

    // Shape geometry.
    localparam int PENT_R    = 8;
    localparam int PENT_BOX  = 16;
    localparam int CIRC_R    = 10;
    localparam int CIRC_LIM  = (CIRC_R + 1) * (CIRC_R + 1);
    localparam int GRID_LOG2 = 6;

    localparam int PENT_AX_BITS = $clog2(PENT_BOX + 1);
    localparam int PENT_Y_BITS  = PENT_AX_BITS + 1;
    localparam int CIRC_A_BITS  = $clog2(CIRC_R + 1);

    // Pentagon fold constants with 30 fraction bits.
    localparam logic [31:0] KX30 = 32'd868675383;
    localparam logic [31:0] KY30 = 32'd631129609;
    localparam logic [31:0] KZ30 = 32'd780119099;

    // Register stages inside the pentagon pipeline.
    localparam int PENT_STAGES = 10;

    typedef struct packed {
        logic valid;
        logic en;
        logic side_lit;
    } sdfspc_ctl_t;

    // Round a 30-fraction-bit constant to nearest at frac fraction bits.
    function automatic logic [31:0] kq(input logic [31:0] k30, input int frac);
        kq = (k30 + (32'd1 << (29 - frac))) >> (30 - frac);
    endfunction

endpackage

@@ hw/rtl/sdfspc_pentagon.sv @@
module sdfspc_pentagon
    import sdfspc_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sdfspc_ctl_t                   ctl_in,
    input  logic [PENT_AX_BITS-1:0]       ax_in,
    input  logic signed [PENT_Y_BITS-1:0] y_in,
    output logic                          done,
    output logic                          lit
);

    localparam int W  = FRAC_BITS + 8;
    localparam int PW = W + FRAC_BITS + 1;

    localparam logic signed [FRAC_BITS:0] KX = (FRAC_BITS+1)'(kq(KX30, FRAC_BITS));
    localparam logic signed [FRAC_BITS:0] KY = (FRAC_BITS+1)'(kq(KY30, FRAC_BITS));
    localparam logic signed [W-1:0] LIM = W'(longint'(kq(KZ30, FRAC_BITS)) * PENT_R);
    localparam logic signed [W-1:0] PY_OFFSET = W'(longint'(PENT_R) << FRAC_BITS);
    localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
    localparam logic [2*W:0] ONE_SQ = (2*W+1)'(1) << (2 * FRAC_BITS);

    // Round to nearest, ties away from zero, dropping FRAC_BITS fraction bits.
    function automatic logic signed [W-1:0] qround(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] biased;
        biased = p + HALF - PW'(p[PW-1]);
        qround = W'(biased >>> FRAC_BITS);
    endfunction

    sdfspc_ctl_t ctl_reg [1:PENT_STAGES];

    logic signed [W-1:0]        t0_reg;
    logic [PENT_AX_BITS-1:0]    ax1_reg, ax2_reg;
    logic signed [PENT_Y_BITS-1:0] y1_reg, y2_reg;
    logic signed [PW-1:0]       pxk_reg, pyk_reg;
    logic signed [W-1:0]        px3_reg, py3_reg;
    logic signed [PW-1:0]       pa_reg, pb_reg;
    logic signed [W-1:0]        px4_reg, py4_reg;
    logic signed [W-1:0]        d1_reg, px5_reg, py5_reg;
    logic signed [PW-1:0]       prx_reg, pry_reg;
    logic signed [W-1:0]        px6_reg, py6_reg;
    logic signed [W-1:0]        px7_reg, py7_reg;
    logic signed [W-1:0]        px8_reg, py8_reg;
    logic [2*W-1:0]             sqx_reg, sqy_reg;
    logic                       neg_reg;
    logic                       lit_reg;

    logic signed [PENT_Y_BITS-1:0] ax_s;
    logic signed [W-1:0]        t0_next;
    logic signed [W-1:0]        d0;
    logic signed [PW-1:0]       pxk_next, pyk_next;
    logic signed [W-1:0]        px0, py0, px3_next, py3_next;
    logic signed [PW-1:0]       pa_next, pb_next;
    logic signed [W-1:0]        dsum, d1_next;
    logic signed [PW-1:0]       prx_next, pry_next;
    logic signed [W-1:0]        px7_next, py7_next;
    logic signed [W-1:0]        px8_next, py8_next;
    logic [2*W-1:0]             sqx_next, sqy_next;
    logic [2*W:0]               sq_sum;
    logic                       lit_next;

    always_comb
    begin
        // First fold: distance to the plane through the left edge normal.
        ax_s    = PENT_Y_BITS'(ax_in);
        t0_next = W'(y_in * KY) - W'(ax_s * KX);

        d0       = (t0_reg > 0) ? '0 : (t0_reg <<< 1);
        pxk_next = PW'((-d0) * KX);
        pyk_next = PW'(d0 * KY);

        px0      = W'(ax2_reg) << FRAC_BITS;
        py0      = W'(y2_reg) <<< FRAC_BITS;
        px3_next = px0 - qround(pxk_reg);
        py3_next = py0 - qround(pyk_reg);

        // Second fold, mirrored normal.
        pa_next = PW'(px3_reg * KX);
        pb_next = PW'(py3_reg * KY);

        dsum    = qround(pa_reg) + qround(pb_reg);
        d1_next = (dsum > 0) ? '0 : (dsum <<< 1);

        prx_next = PW'(d1_reg * KX);
        pry_next = PW'(d1_reg * KY);

        px7_next = px6_reg - qround(prx_reg);
        py7_next = py6_reg - qround(pry_reg);

        // Distance to the clamped top edge segment.
        if (px7_reg > LIM)
        begin
            px8_next = px7_reg - LIM;
        end
        else if (px7_reg < -LIM)
        begin
            px8_next = px7_reg + LIM;
        end
        else
        begin
            px8_next = '0;
        end
        py8_next = py7_reg - PY_OFFSET;

        sqx_next = (2*W)'(px8_reg * px8_reg);
        sqy_next = (2*W)'(py8_reg * py8_reg);

        sq_sum   = (2*W+1)'(sqx_reg) + (2*W+1)'(sqy_reg);
        lit_next = ctl_reg[PENT_STAGES-1].side_lit
                 | (ctl_reg[PENT_STAGES-1].en & (neg_reg | (sq_sum < ONE_SQ)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= PENT_STAGES; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else
        begin
            ctl_reg[1] <= ctl_in;
            for (int i = 2; i <= PENT_STAGES; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t0_reg  <= t0_next;
        ax1_reg <= ax_in;
        y1_reg  <= y_in;

        pxk_reg <= pxk_next;
        pyk_reg <= pyk_next;
        ax2_reg <= ax1_reg;
        y2_reg  <= y1_reg;

        px3_reg <= px3_next;
        py3_reg <= py3_next;

        pa_reg  <= pa_next;
        pb_reg  <= pb_next;
        px4_reg <= px3_reg;
        py4_reg <= py3_reg;

        d1_reg  <= d1_next;
        px5_reg <= px4_reg;
        py5_reg <= py4_reg;

        prx_reg <= prx_next;
        pry_reg <= pry_next;
        px6_reg <= px5_reg;
        py6_reg <= py5_reg;

        px7_reg <= px7_next;
        py7_reg <= py7_next;

        px8_reg <= px8_next;
        py8_reg <= py8_next;

        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
        neg_reg <= py8_reg[W-1];

        lit_reg <= lit_next;
    end

    assign done = ctl_reg[PENT_STAGES].valid;
    assign lit  = lit_reg;

endmodule

@@ hw/rtl/sdf_shape_pixel_coverage.sv @@
// Channel   Direction  Signals                                 Handshake
// -------   ---------  --------------------------------------  --------------------------
// pixel     in         start, busy, pixel_x, pixel_y           start && !busy
// result    out        done, lit                               done, one cycle, no stall
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// One item is accepted every clock; done follows start through the two front
// stages and the pentagon pipeline: two folds, each with multiply and rounding
// stages, then the edge clamp and the squared length.
// Reset clears the config registers to zero and empties the pipeline.
// The receiver cannot stall, so busy stays low and cfg_ready stays high.
module sdf_shape_pixel_coverage
    import sdfspc_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [COORD_BITS-1:0]     pixel_x,
    input  logic [COORD_BITS-1:0]     pixel_y,
    output logic                      done,
    output logic                      lit,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int DW = ((COORD_BITS > 11) ? COORD_BITS : 11) + 3;
    localparam int CSW = 2 * CIRC_A_BITS + 1;
    localparam int LATENCY = 2 + PENT_STAGES;

    logic [HALF_BITS-1:0]          hw_reg, hh_reg;
    logic signed [PSHIFT_BITS-1:0] psx_reg, psy_reg;
    logic signed [CSHIFT_BITS-1:0] csx_reg, csy_reg;

    logic                          accept;
    logic signed [DW-1:0]          u_s, v_s, hw_s, hh_s;
    logic signed [DW-1:0]          pdx, pdy, cdx, cdy;
    logic signed [DW-1:0]          pdx_abs, cdx_abs, cdy_abs;
    logic                          pen_in, circ_in, grid;

    logic                          s1_valid_reg;
    logic [PENT_AX_BITS-1:0]       s1_ax_reg;
    logic signed [PENT_Y_BITS-1:0] s1_y_reg;
    logic                          s1_pen_reg, s1_cin_reg, s1_grid_reg;
    logic [CIRC_A_BITS-1:0]        s1_cx_reg, s1_cy_reg;

    logic                          s2_valid_reg;
    logic [PENT_AX_BITS-1:0]       s2_ax_reg;
    logic signed [PENT_Y_BITS-1:0] s2_y_reg;
    logic                          s2_pen_reg, s2_side_reg;

    logic [CSW-1:0]                csum;
    logic                          side_next;
    sdfspc_ctl_t                   pent_ctl;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg  <= '0;
            hh_reg  <= '0;
            psx_reg <= '0;
            psy_reg <= '0;
            csx_reg <= '0;
            csy_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HALF_WIDTH:       hw_reg  <= cfg_data[HALF_BITS-1:0];
                REG_HALF_HEIGHT:      hh_reg  <= cfg_data[HALF_BITS-1:0];
                REG_PENTAGON_SHIFT_X: psx_reg <= cfg_data[PSHIFT_BITS-1:0];
                REG_PENTAGON_SHIFT_Y: psy_reg <= cfg_data[PSHIFT_BITS-1:0];
                REG_CIRCLE_SHIFT_X:   csx_reg <= cfg_data[CSHIFT_BITS-1:0];
                REG_CIRCLE_SHIFT_Y:   csy_reg <= cfg_data[CSHIFT_BITS-1:0];
                default:              ;
            endcase
        end
    end

    // Stage 1: offsets from both shape centers, the box tests and the grid test.
    always_comb
    begin
        u_s  = DW'({1'b0, pixel_x});
        v_s  = DW'({1'b0, pixel_y});
        hw_s = DW'({1'b0, hw_reg});
        hh_s = DW'({1'b0, hh_reg});

        pdx = u_s - (hw_s + DW'(psx_reg));
        pdy = v_s - (hh_s + DW'(psy_reg));
        cdx = u_s - (hw_s + DW'(csx_reg));
        cdy = v_s - (hh_s + DW'(csy_reg));

        pen_in  = (pdx >= -PENT_BOX) && (pdx <= PENT_BOX)
               && (pdy >= -PENT_BOX) && (pdy <= PENT_BOX);
        circ_in = (cdx >= -CIRC_R) && (cdx <= CIRC_R)
               && (cdy >= -CIRC_R) && (cdy <= CIRC_R);

        pdx_abs = pdx[DW-1] ? -pdx : pdx;
        cdx_abs = cdx[DW-1] ? -cdx : cdx;
        cdy_abs = cdy[DW-1] ? -cdy : cdy;

        grid = (pixel_x[GRID_LOG2-1:0] == '0) || (pixel_y[GRID_LOG2-1:0] == '0);
    end

    // Stage 2: circle test and grid merged into one side bit.
    always_comb
    begin
        csum = CSW'(s1_cx_reg * s1_cx_reg) + CSW'(s1_cy_reg * s1_cy_reg);
        side_next = s1_grid_reg || (s1_cin_reg && (csum < CSW'(CIRC_LIM)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ax_reg   <= pdx_abs[PENT_AX_BITS-1:0];
        s1_y_reg    <= pdy[PENT_Y_BITS-1:0];
        s1_pen_reg  <= pen_in;
        s1_cx_reg   <= cdx_abs[CIRC_A_BITS-1:0];
        s1_cy_reg   <= cdy_abs[CIRC_A_BITS-1:0];
        s1_cin_reg  <= circ_in;
        s1_grid_reg <= grid;

        s2_ax_reg   <= s1_ax_reg;
        s2_y_reg    <= s1_y_reg;
        s2_pen_reg  <= s1_pen_reg;
        s2_side_reg <= side_next;
    end

    assign pent_ctl.valid    = s2_valid_reg;
    assign pent_ctl.en       = s2_pen_reg;
    assign pent_ctl.side_lit = s2_side_reg;

    sdfspc_pentagon #(
        .FRAC_BITS(FRAC_BITS)
    ) u_pentagon (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (pent_ctl),
        .ax_in  (s2_ax_reg),
        .y_in   (s2_y_reg),
        .done   (done),
        .lit    (lit)
    );

    // Every accepted item comes out on done, and done comes only for an accepted item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item did not complete on time");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching accepted item");

    // A pixel on a grid column is always lit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (pixel_x[GRID_LOG2-1:0] == '0)) |-> ##LATENCY lit)
        else $error("grid column pixel not lit");

endmodule
